>>> hw/rtl/value_noise_2d_cosine_unit_defines.svh
`ifndef VALUE_NOISE_2D_COSINE_UNIT_DEFINES_SVH
`define VALUE_NOISE_2D_COSINE_UNIT_DEFINES_SVH

// property holds on every clock edge outside reset
`define VN2C_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("vn2c assertion failed");

// expression never true outside reset
`define VN2C_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("vn2c forbidden condition seen");

`endif

>>> hw/rtl/vn2c_pkg.sv
package vn2c_pkg;

	localparam int HW = 31;
	localparam int WW = 16;
	localparam int VW = 16;
	localparam int TAB_BITS = 8;
	localparam int TAB_SIZE = 256;
	localparam int TAB_HALF = TAB_SIZE / 2;

	localparam logic [HW-1:0] HASH_Y_MUL = 31'd57;
	localparam int HASH_SHIFT = 13;
	localparam logic [HW-1:0] HASH_C1 = 31'd60493;
	localparam logic [HW-1:0] HASH_C2 = 31'd19990303;
	localparam logic [HW-1:0] HASH_C3 = 31'd1376312589;
	localparam int HASH_LO = 16;

	localparam logic signed [VW-1:0] CORNER_ONE = 16'sd16384;
	localparam logic signed [33:0] BLEND_RND = 34'sd32768;

	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	typedef logic [WW-1:0] weight_t;
	typedef logic signed [VW-1:0] value_t;
	typedef logic [TAB_SIZE-1:0][WW-1:0] wtab_t;

	// shift-subtract quotient, only used while building the table
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = 64'd0;
		rem = 65'd0;
		for (int j = 63; j >= 0; j--) begin
			rem = {rem[63:0], num[j]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[j] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic weight_t half_cos(input logic [8:0] i);
		logic [63:0] t;
		logic [63:0] t2;
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] acc;
		logic [63:0] den;
		t = (PI_Q30 * 64'(i)) >> 8;
		t2 = (t * t) >> 30;
		term = t2 >> 1;
		pos = term;
		neg = 64'd0;
		for (int k = 2; k <= 10; k++) begin
			den = 64'((2 * k - 1) * (2 * k));
			term = udiv64((term * t2) >> 30, den);
			if ((k & 1) == 1) begin
				pos = pos + term;
			end else begin
				neg = neg + term;
			end
		end
		acc = (pos > neg) ? pos - neg : 64'd0;
		return WW'((acc + 64'd16384) >> 15);
	endfunction

	function automatic wtab_t build_wtab();
		wtab_t w;
		for (int i = 0; i < TAB_SIZE; i++) begin
			if (i <= TAB_HALF) begin
				w[i] = half_cos(9'(i));
			end else begin
				w[i] = WW'(17'd65536 - 17'(half_cos(9'(TAB_SIZE - i))));
			end
		end
		return w;
	endfunction

	localparam wtab_t WTAB = build_wtab();

endpackage

>>> hw/rtl/vn2c_hash.sv
module vn2c_hash (
	input  logic                           clk,
	input  logic [vn2c_pkg::HW-1:0]        n,
	output vn2c_pkg::value_t               corner
);

	logic [vn2c_pkg::HW-1:0] m_s1, m_s2, m_s3;
	logic [vn2c_pkg::HW-1:0] sq_s2;
	logic [vn2c_pkg::HW-1:0] p_s3;
	logic [vn2c_pkg::HW-1:0] h;
	logic [vn2c_pkg::HW-vn2c_pkg::HASH_LO-1:0] hi_s4;
	vn2c_pkg::value_t corner_s5;

	assign h = m_s3 * p_s3 + vn2c_pkg::HASH_C3;

	always_ff @(posedge clk) begin
		m_s1 <= n ^ (n << vn2c_pkg::HASH_SHIFT);
		sq_s2 <= m_s1 * m_s1;
		m_s2 <= m_s1;
		p_s3 <= sq_s2 * vn2c_pkg::HASH_C1 + vn2c_pkg::HASH_C2;
		m_s3 <= m_s2;
		hi_s4 <= h[vn2c_pkg::HW-1:vn2c_pkg::HASH_LO];
		corner_s5 <= vn2c_pkg::CORNER_ONE - $signed({1'b0, hi_s4});
	end

	assign corner = corner_s5;

endmodule

>>> hw/rtl/vn2c_lerp.sv
module vn2c_lerp (
	input  logic                  clk,
	input  vn2c_pkg::value_t      a,
	input  vn2c_pkg::value_t      b,
	input  vn2c_pkg::weight_t     w,
	output vn2c_pkg::value_t      r
);

	logic signed [16:0] diff;
	logic signed [33:0] prod;
	logic signed [33:0] pr_s1;
	vn2c_pkg::value_t a_s1;
	logic signed [17:0] q;
	vn2c_pkg::value_t r_s2;

	assign diff = 17'(b) - 17'(a);
	assign prod = 34'(diff) * 34'($signed({1'b0, w})) + vn2c_pkg::BLEND_RND;
	assign q = $signed(pr_s1[33:16]);

	always_ff @(posedge clk) begin
		pr_s1 <= prod;
		a_s1 <= a;
		r_s2 <= 16'(18'(a_s1) + q);
	end

	assign r = r_s2;

endmodule

>>> hw/rtl/value_noise_2d_cosine_unit.sv
// 2d value noise with cosine blending, fully pipelined.
// input transaction: x_coord and y_coord, unsigned fixed point with INT_BITS
// integer and FRAC_BITS fraction bits, taken on a clock edge with start high
// and busy low. busy is always low: a new coordinate can enter every cycle.
// result transaction: noise_value, signed q1.14, shown for one cycle while
// done is high.
// throughput is one result per cycle. the pipeline holds one stage for the
// lattice sum and weight lookup, five stages of the corner hash multiplier
// chain, two stages for the x blend and two stages for the y blend.
// results leave in the order the coordinates entered.
// reset clears the valid pipeline only; no result is produced for anything
// in flight at reset. no table fill is needed, the weight rom is constant.
// the receiver cannot stall, so there is no backpressure path.
module value_noise_2d_cosine_unit #(
	parameter int FRAC_BITS = 8,
	parameter int INT_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [INT_BITS+FRAC_BITS-1:0] x_coord,
	input  logic [INT_BITS+FRAC_BITS-1:0] y_coord,
	output logic                          done,
	output logic signed [15:0]            noise_value
);

	localparam int CW = INT_BITS + FRAC_BITS;
	localparam int TB = vn2c_pkg::TAB_BITS;

	logic [INT_BITS-1:0] xi, yi;
	logic [TB-1:0] idx_x, idx_y;
	logic [vn2c_pkg::HW-1:0] n00_s1;
	logic [vn2c_pkg::HW-1:0] n00, n10, n01, n11;
	vn2c_pkg::weight_t wx_s1, wx_s2, wx_s3, wx_s4, wx_s5, wx_s6;
	vn2c_pkg::weight_t wy_s1, wy_s2, wy_s3, wy_s4, wy_s5, wy_s6, wy_s7, wy_s8;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	vn2c_pkg::value_t c00, c10, c01, c11;
	vn2c_pkg::value_t r0, r1, r;

	assign xi = x_coord[CW-1:FRAC_BITS];
	assign yi = y_coord[CW-1:FRAC_BITS];

	if (FRAC_BITS >= TB) begin : g_idx_dn
		assign idx_x = x_coord[FRAC_BITS-1 -: TB];
		assign idx_y = y_coord[FRAC_BITS-1 -: TB];
	end else begin : g_idx_up
		assign idx_x = {x_coord[FRAC_BITS-1:0], {(TB-FRAC_BITS){1'b0}}};
		assign idx_y = {y_coord[FRAC_BITS-1:0], {(TB-FRAC_BITS){1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		n00_s1 <= vn2c_pkg::HW'(xi) + vn2c_pkg::HW'(yi) * vn2c_pkg::HASH_Y_MUL;
		wx_s1 <= vn2c_pkg::WTAB[idx_x];
		wy_s1 <= vn2c_pkg::WTAB[idx_y];
		wx_s2 <= wx_s1;
		wx_s3 <= wx_s2;
		wx_s4 <= wx_s3;
		wx_s5 <= wx_s4;
		wx_s6 <= wx_s5;
		wy_s2 <= wy_s1;
		wy_s3 <= wy_s2;
		wy_s4 <= wy_s3;
		wy_s5 <= wy_s4;
		wy_s6 <= wy_s5;
		wy_s7 <= wy_s6;
		wy_s8 <= wy_s7;
	end

	// neighbor corners differ by one step in x and by the row stride in y
	assign n00 = n00_s1;
	assign n10 = n00_s1 + vn2c_pkg::HW'(1);
	assign n01 = n00_s1 + vn2c_pkg::HASH_Y_MUL;
	assign n11 = n00_s1 + vn2c_pkg::HASH_Y_MUL + vn2c_pkg::HW'(1);

	vn2c_hash u_hash00 (.clk(clk), .n(n00), .corner(c00));
	vn2c_hash u_hash10 (.clk(clk), .n(n10), .corner(c10));
	vn2c_hash u_hash01 (.clk(clk), .n(n01), .corner(c01));
	vn2c_hash u_hash11 (.clk(clk), .n(n11), .corner(c11));

	vn2c_lerp u_lerp_x0 (.clk(clk), .a(c00), .b(c10), .w(wx_s6), .r(r0));
	vn2c_lerp u_lerp_x1 (.clk(clk), .a(c01), .b(c11), .w(wx_s6), .r(r1));
	vn2c_lerp u_lerp_y (.clk(clk), .a(r0), .b(r1), .w(wy_s8), .r(r));

	assign busy = 1'b0;
	assign done = v_s10;
	assign noise_value = r;

endmodule

>>> hw/rtl/vn2c_chk.sv
`include "value_noise_2d_cosine_unit_defines.svh"

module vn2c_chk #(
	parameter int LATENCY = 10
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [15:0] noise_value
);

	`VN2C_ASSERT(a_result_follows, clk, arst_n, (start && !busy) |-> ##LATENCY done)
	`VN2C_ASSERT(a_result_has_source, clk, arst_n, done |-> $past(start && !busy, LATENCY))
	`VN2C_ASSERT(a_value_range, clk, arst_n, done |-> (noise_value >= -16'sd16384 && noise_value <= 16'sd16384))
	`VN2C_ASSERT_NEVER(a_never_busy, clk, arst_n, busy)

endmodule

bind value_noise_2d_cosine_unit vn2c_chk #(.LATENCY(10)) u_vn2c_chk (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.noise_value(noise_value)
);

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int FRAC = 8;
	localparam int INTB = 16;
	localparam int CW = INTB + FRAC;
	localparam int PIPE_DEPTH = 10;
	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_COORDS = 500;
	localparam int N_ROWS = 18;

	localparam logic [31:0] ROW_STRIDE = 32'd57;
	localparam int MIX_SHIFT = 13;
	localparam logic [31:0] POLY_A = 32'd60493;
	localparam logic [31:0] POLY_B = 32'd19990303;
	localparam logic [31:0] POLY_C = 32'd1376312589;
	localparam logic [31:0] HASH_MASK = 32'h7fff_ffff;
	localparam int UNIT = 16384;
	localparam logic [63:0] PI_FIX30 = 64'd3373259426;

	typedef struct packed {
		logic [CW-1:0]        x;
		logic [CW-1:0]        y;
		logic                 typed;
		logic signed [15:0]   noise;
	} coord_row_t;

	typedef struct {
		logic [CW-1:0]        x;
		logic [CW-1:0]        y;
		logic signed [15:0]   noise;
	} noise_expect_t;

	// the origin hashes n = 0, so its value is 16384 - (1376312589 >> 16)
	coord_row_t coord_table [N_ROWS] = '{
		'{24'h000000, 24'h000000, 1'b1, -16'sd4616},
		'{24'h000080, 24'h000000, 1'b0, 16'sd0},
		'{24'h000000, 24'h000080, 1'b0, 16'sd0},
		'{24'h000080, 24'h000080, 1'b0, 16'sd0},
		'{24'h0000ff, 24'h0000ff, 1'b0, 16'sd0},
		'{24'h000001, 24'h000001, 1'b0, 16'sd0},
		'{24'h00007f, 24'h000081, 1'b0, 16'sd0},
		'{24'hffffff, 24'hffffff, 1'b0, 16'sd0},
		'{24'hffff00, 24'h000000, 1'b0, 16'sd0},
		'{24'h000000, 24'hffff00, 1'b0, 16'sd0},
		'{24'hffffff, 24'h000000, 1'b0, 16'sd0},
		'{24'h000000, 24'hffffff, 1'b0, 16'sd0},
		'{24'haaaaaa, 24'h555555, 1'b0, 16'sd0},
		'{24'h555555, 24'haaaaaa, 1'b0, 16'sd0},
		'{24'hffff80, 24'hffff80, 1'b0, 16'sd0},
		'{24'h123456, 24'h654321, 1'b0, 16'sd0},
		'{24'h000100, 24'h000000, 1'b0, 16'sd0},
		'{24'h800040, 24'h7fffc0, 1'b0, 16'sd0}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [CW-1:0]       x_coord = '0;
	logic [CW-1:0]       y_coord = '0;
	logic                done;
	logic signed [15:0]  noise_value;

	logic [16:0]         cos_lut [256];
	noise_expect_t       pending_noise [$];
	noise_expect_t       oldest;
	int                  coords_sent = 0;
	int                  noise_checked = 0;
	int                  mismatches = 0;
	int                  stall_cycles = 0;
	bit                  burst = 1'b0;
	int                  run_left = 0;

	value_noise_2d_cosine_unit #(
		.FRAC_BITS(FRAC),
		.INT_BITS (INTB)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.x_coord    (x_coord),
		.y_coord    (y_coord),
		.done       (done),
		.noise_value(noise_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// (1 - cos(pi*i/256)) / 2 in q0.16, series evaluated with 30 fraction bits
	function automatic logic [16:0] half_cos_weight(input int unsigned i);
		logic [63:0] ang;
		logic [63:0] ang2;
		logic [63:0] term;
		logic [63:0] plus;
		logic [63:0] minus;
		logic [63:0] acc;
		int k;
		ang = (PI_FIX30 * 64'(i)) >> 8;
		ang2 = (ang * ang) >> 30;
		term = ang2 >> 1;
		plus = term;
		minus = 64'd0;
		for (k = 2; k <= 10; k++) begin
			term = ((term * ang2) >> 30) / 64'((2 * k - 1) * (2 * k));
			if (k % 2 == 1) begin
				plus = plus + term;
			end else begin
				minus = minus + term;
			end
		end
		acc = (plus > minus) ? plus - minus : 64'd0;
		return 17'((acc + 64'd16384) >> 15);
	endfunction

	function automatic int lattice_height(input logic [31:0] cx, input logic [31:0] cy);
		logic [31:0] n;
		logic [31:0] h;
		n = cx + cy * ROW_STRIDE;
		n = (n << MIX_SHIFT) ^ n;
		h = (n * (n * n * POLY_A + POLY_B) + POLY_C) & HASH_MASK;
		return UNIT - int'(h >> 16);
	endfunction

	// a + round half up of (b - a) * w / 65536
	function automatic int cos_mix(input int a, input int b, input logic [16:0] w);
		longint p;
		p = longint'(b - a) * longint'(w) + 64'sd32768;
		return a + int'(p >>> 16);
	endfunction

	function automatic logic signed [15:0] predict_noise(input logic [CW-1:0] xc,
			input logic [CW-1:0] yc);
		logic [31:0] xi;
		logic [31:0] yi;
		logic [16:0] wx;
		logic [16:0] wy;
		int r0;
		int r1;
		xi = 32'(xc[CW-1:FRAC]);
		yi = 32'(yc[CW-1:FRAC]);
		wx = cos_lut[xc[FRAC-1:0]];
		wy = cos_lut[yc[FRAC-1:0]];
		r0 = cos_mix(lattice_height(xi, yi), lattice_height(xi + 32'd1, yi), wx);
		r1 = cos_mix(lattice_height(xi, yi + 32'd1),
			lattice_height(xi + 32'd1, yi + 32'd1), wx);
		return 16'(cos_mix(r0, r1, wy));
	endfunction

	function automatic logic [CW-1:0] pick_coord();
		logic [CW-1:0] c;
		logic [7:0] f;
		case ($urandom_range(0, 4))
			0, 1: begin
				c = CW'($urandom);
			end
			2: begin
				c = {16'hffff - 16'($urandom_range(0, 1)), 8'($urandom)};
			end
			3: begin
				c = {16'($urandom_range(0, 3)), 8'($urandom)};
			end
			default: begin
				case ($urandom_range(0, 4))
					0: f = 8'h00;
					1: f = 8'h01;
					2: f = 8'h7f;
					3: f = 8'h80;
					default: f = 8'hff;
				endcase
				c = {16'($urandom), f};
			end
		endcase
		return c;
	endfunction

	// idle gap before the next transaction, with back-to-back stretches
	task automatic pause();
		int gap;
		if (run_left == 0) begin
			burst = ($urandom_range(0, 3) == 0);
			run_left = $urandom_range(10, 40);
		end
		run_left--;
		gap = burst ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic feed(input logic [CW-1:0] xv, input logic [CW-1:0] yv,
			input logic typed, input logic signed [15:0] typed_noise);
		noise_expect_t e;
		start <= 1'b1;
		x_coord <= xv;
		y_coord <= yv;
		do @(posedge clk); while (busy !== 1'b0);
		e.x = xv;
		e.y = yv;
		e.noise = typed ? typed_noise : predict_noise(xv, yv);
		pending_noise.push_back(e);
		coords_sent++;
	endtask

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (pending_noise.size() == 0) begin
				$display("%0t: unexpected noise_value %0d", $time, noise_value);
				mismatches++;
			end else begin
				oldest = pending_noise.pop_front();
				noise_checked++;
				if (noise_value !== oldest.noise) begin
					$display("%0t: noise_value at x=%h y=%h expected %0d actual %0d",
						$time, oldest.x, oldest.y, oldest.noise, noise_value);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done === 1'b1) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles == STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d results outstanding",
					$time, STALL_LIMIT, pending_noise.size());
				$display("value_noise_2d_cosine_unit: mismatch");
				$finish;
			end
		end
	end

	initial begin
		int i;
		for (i = 0; i < 256; i++) begin
			if (i <= 128) begin
				cos_lut[i] = half_cos_weight(i);
			end else begin
				cos_lut[i] = 17'd65536 - half_cos_weight(256 - i);
			end
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (i = 0; i < N_ROWS; i++) begin
			pause();
			feed(coord_table[i].x, coord_table[i].y, coord_table[i].typed,
				coord_table[i].noise);
		end
		for (i = 0; i < RANDOM_COORDS; i++) begin
			pause();
			feed(pick_coord(), pick_coord(), 1'b0, 16'sd0);
		end
		start <= 1'b0;
		while (pending_noise.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 10) @(posedge clk);
		$display("coordinates sent: %0d (%0d table rows, rest random incl. range top)",
			coords_sent, N_ROWS);
		$display("noise values checked: %0d, mismatches: %0d", noise_checked, mismatches);
		if (mismatches == 0) begin
			$display("value_noise_2d_cosine_unit: match");
		end else begin
			$display("value_noise_2d_cosine_unit: mismatch");
		end
		$finish;
	end

endmodule
